// ===== src/i2a_pkg.sv =====
// Shared constants, types and helpers for the integer-to-ASCII radix converter.
package i2a_pkg;

    localparam int ValueBitsDef = 32;
    localparam int MaxChars     = 32;
    localparam int MaxMinDigits = 32;
    localparam int RadixMin     = 2;
    localparam int RadixMax     = 16;
    localparam int DecRadix     = 10;
    localparam int RadixW       = 5;
    localparam int MinDigW      = 6;
    localparam int DigitW       = 4;
    localparam int CharW        = 8;
    localparam int StkIdxW      = $clog2(MaxChars);
    localparam int StkCntW      = $clog2(MaxChars + 1);

    localparam logic [CharW-1:0] CharZero  = 8'h30;
    localparam logic [CharW-1:0] CharA     = 8'h61;
    localparam logic [CharW-1:0] CharMinus = 8'h2d;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic again;
    } div_ctrl_t;

    typedef struct packed {
        logic              done;
        logic              quot_nz;
        logic [DigitW-1:0] digit;
    } div_stat_t;

    typedef struct packed {
        logic             push;
        logic             pop_en;
        logic [CharW-1:0] ch;
    } stk_ctrl_t;

    function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d);
        logic [CharW-1:0] dx;
        dx = {{(CharW-DigitW){1'b0}}, d};
        if (d < DigitW'(DecRadix))
            return CharZero + dx;
        else
            return CharA + dx - CharW'(DecRadix);
    endfunction

endpackage

// ===== src/i2a_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, remainder is the digit.
module i2a_div
    import i2a_pkg::*;
#(
    parameter int VALUE_BITS = ValueBitsDef
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  div_ctrl_t             ctrl,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [RadixW-1:0]     radix,
    output div_stat_t             stat
);

    localparam int CntW = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] q_reg,    q_next;
    logic [DigitW-1:0]     rem_reg,  rem_next;
    logic [CntW-1:0]       cnt_reg,  cnt_next;
    logic                  run_reg,  run_next;
    logic                  done_reg, done_next;
    logic                  nz_reg,   nz_next;

    logic [RadixW-1:0] trial;
    logic [RadixW-1:0] diff;
    logic              ge;

    // remainder stays below radix <= 16, so four bits hold it
    assign trial = {rem_reg, q_reg[VALUE_BITS-1]};
    assign ge    = (trial >= radix);
    assign diff  = trial - radix;

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        nz_next   = nz_reg;
        done_next = 1'b0;
        if (ctrl.load || ctrl.again)
        begin
            if (ctrl.load)
                q_next = dividend;
            rem_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
            nz_next  = 1'b0;
        end
        else if (run_reg)
        begin
            q_next   = {q_reg[VALUE_BITS-2:0], ge};
            rem_next = ge ? diff[DigitW-1:0] : trial[DigitW-1:0];
            nz_next  = nz_reg | ge;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(VALUE_BITS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        nz_reg  <= nz_next;
    end

    assign stat.done    = done_reg;
    assign stat.quot_nz = nz_reg;
    assign stat.digit   = rem_reg;

endmodule

// ===== src/i2a_stk.sv =====
// Character stack: digits go in least significant first, come out reversed
// through the output register.
module i2a_stk
    import i2a_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  stk_ctrl_t          ctrl,
    output logic [StkCntW-1:0] count,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [CharW-1:0]   m_tdata,   // char_out
    output logic               m_tlast    // last
);

    logic [CharW-1:0]   mem_reg [MaxChars];
    logic [StkCntW-1:0] cnt_reg,   cnt_next;
    logic               vld_reg,   vld_next;
    logic [CharW-1:0]   data_reg;
    logic               last_reg;
    logic [StkCntW-1:0] top;
    logic               pop;

    assign top = cnt_reg - 1'b1;
    assign pop = ctrl.pop_en && (cnt_reg != '0) && (!vld_reg || m_tready);

    always_comb
    begin
        cnt_next = cnt_reg;
        vld_next = vld_reg;
        if (m_tready)
            vld_next = 1'b0;
        if (pop)
        begin
            cnt_next = cnt_reg - 1'b1;
            vld_next = 1'b1;
        end
        else if (ctrl.push)
            cnt_next = cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            vld_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
            mem_reg[cnt_reg[StkIdxW-1:0]] <= ctrl.ch;
        if (pop)
        begin
            data_reg <= mem_reg[top[StkIdxW-1:0]];
            last_reg <= (cnt_reg == StkCntW'(1));
        end
    end

    assign count    = cnt_reg;
    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== src/integer_to_ascii_radix_core.sv =====
// Top level of the integer-to-ASCII radix converter.
//
// Takes one number per item and sends its text in radix 2..16, one character
// per output item, most significant digit first, with tlast on the final one.
// Digits come from a bit-serial divider that produces one quotient bit per
// cycle; a sign character, if any, is stored after the last digit, and the
// stored text then drains at one character per cycle while m_tready is high.
// One number is worked on at a time; s_tready is high only while idle, and the
// final character of the previous number may still wait in the output register.
// Radix saturates to 2..16, min_digits to 32; at most 32 characters are sent,
// and when the text would be longer its leading characters are dropped.
module integer_to_ascii_radix_core
    import i2a_pkg::*;
#(
    parameter int VALUE_BITS = ValueBitsDef,
    parameter int IN_W       = ((VALUE_BITS + RadixW + MinDigW + 7) / 8) * 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,   // value, radix, min_digits (zero pad)
    input  logic            s_tuser,   // is_signed
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,   // char_out
    output logic            m_tlast    // last
);

    state_t              state_reg, state_next;
    logic [RadixW-1:0]   radix_reg, radix_next;
    logic [MinDigW-1:0]  md_reg,    md_next;
    logic                neg_reg,   neg_next;

    logic [VALUE_BITS-1:0] in_value;
    logic [RadixW-1:0]     in_radix;
    logic [MinDigW-1:0]    in_md;
    logic [RadixW-1:0]     radix_sat;
    logic [MinDigW-1:0]    md_sat;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] magnitude;

    div_ctrl_t          div_ctrl;
    div_stat_t          div_stat;
    stk_ctrl_t          stk_ctrl;
    logic [StkCntW-1:0] stk_count;
    logic               room;

    assign in_value = s_tdata[VALUE_BITS-1:0];
    assign in_radix = s_tdata[VALUE_BITS +: RadixW];
    assign in_md    = s_tdata[VALUE_BITS+RadixW +: MinDigW];

    always_comb
    begin
        if (in_radix < RadixW'(RadixMin))
            radix_sat = RadixW'(RadixMin);
        else if (in_radix > RadixW'(RadixMax))
            radix_sat = RadixW'(RadixMax);
        else
            radix_sat = in_radix;
        md_sat = (in_md > MinDigW'(MaxMinDigits)) ? MinDigW'(MaxMinDigits) : in_md;
    end

    assign in_neg    = s_tuser && (radix_sat == RadixW'(DecRadix)) && in_value[VALUE_BITS-1];
    assign magnitude = in_neg ? (~in_value + 1'b1) : in_value;

    // room for another character after the one pushed this cycle
    assign room = (stk_count < StkCntW'(MaxChars - 1));

    always_comb
    begin
        state_next      = state_reg;
        radix_next      = radix_reg;
        md_next         = md_reg;
        neg_next        = neg_reg;
        s_tready        = 1'b0;
        div_ctrl.load   = 1'b0;
        div_ctrl.again  = 1'b0;
        stk_ctrl.push   = 1'b0;
        stk_ctrl.pop_en = 1'b0;
        stk_ctrl.ch     = digit_char(div_stat.digit);
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    radix_next    = radix_sat;
                    md_next       = md_sat;
                    neg_next      = in_neg;
                    div_ctrl.load = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    stk_ctrl.push = 1'b1;
                    md_next = (md_reg == '0) ? '0 : md_reg - 1'b1;
                    if ((div_stat.quot_nz || (md_reg > MinDigW'(1))) && room)
                        div_ctrl.again = 1'b1;
                    else if (neg_reg && room)
                        state_next = ST_SIGN;
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                stk_ctrl.push = 1'b1;
                stk_ctrl.ch   = CharMinus;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                stk_ctrl.pop_en = 1'b1;
                if (stk_count == '0)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        radix_reg <= radix_next;
        md_reg    <= md_next;
        neg_reg   <= neg_next;
    end

    i2a_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (magnitude),
        .radix    (radix_reg),
        .stat     (div_stat)
    );

    i2a_stk u_stk (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (stk_ctrl),
        .count    (stk_count),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== src/i2a_chk.sv =====
// Port-level checker for the integer-to-ASCII radix converter, bound to the top.
module i2a_chk
    import i2a_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            s_tvalid,
    input logic            s_tready,
    input logic            m_tvalid,
    input logic            m_tready,
    input logic [7:0]      m_tdata,
    input logic            m_tlast
);

    // stalled output holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // no new number is taken while one is still being sent
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input accepted in the middle of a number");

    // the first character needs a full division pass
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !(m_tvalid && !m_tlast))
        else $error("character of a new number too early");

    a_charset: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata >= CharZero && m_tdata < CharZero + CharW'(DecRadix))
                  || (m_tdata >= CharA && m_tdata < CharA + CharW'(RadixMax - DecRadix))
                  || (m_tdata == CharMinus))
        else $error("character outside digit set");

    a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata == CharMinus) |-> !m_tlast)
        else $error("sign sent as final character");

endmodule

bind integer_to_ascii_radix_core i2a_chk u_i2a_chk (.*);
